// File: rtl/core/sliding_correlator_macros.svh
// ----------------------------------------------------------------------------
// sliding_correlator_macros.svh
// Assertion macros used by the correlator top level.
// ----------------------------------------------------------------------------
`ifndef SLIDING_CORRELATOR_MACROS_SVH
`define SLIDING_CORRELATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SLC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SLC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/slcorr_pkg.sv
// ----------------------------------------------------------------------------
// slcorr_pkg
// Operation codes, sequencer states and shared widths of the correlator.
// ----------------------------------------------------------------------------
package slcorr_pkg;

	localparam int CORR_BITS      = 38;
	localparam int NUM_TAPS_BITS  = 7;
	localparam int TAP_INDEX_BITS = 6;
	localparam int VALUE_BITS     = 16;

	localparam logic [NUM_TAPS_BITS-1:0] NUM_TAPS_RESET = 7'd64;

	// Code 3 is unused and ignored.
	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_PUSH    = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	// One tap step issued to the store and the multiply-accumulate pipe.
	typedef struct packed {
		logic issue;
		logic first;
		logic last;
	} mac_ctl_t;

endpackage

// File: rtl/core/slcorr_store.sv
// ----------------------------------------------------------------------------
// slcorr_store
// Coefficient memory and circular sample history, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module slcorr_store import slcorr_pkg::*; #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
	input  logic                   clk,
	input  logic                   coef_we,
	input  logic [AW-1:0]          coef_waddr,
	input  logic                   hist_we,
	input  logic [AW-1:0]          hist_waddr,
	input  logic [SAMPLE_BITS-1:0] wdata,
	input  mac_ctl_t               mac_ctl,
	input  logic [AW-1:0]          coef_raddr,
	input  logic [AW-1:0]          hist_raddr,
	output logic [SAMPLE_BITS-1:0] coef_s1,
	output logic [SAMPLE_BITS-1:0] hist_s1
);

	logic [SAMPLE_BITS-1:0] coef_mem [MAX_TAPS];
	logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_waddr] <= wdata;
		end
		if (mac_ctl.issue) begin
			coef_s1 <= coef_mem[coef_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= wdata;
		end
		if (mac_ctl.issue) begin
			hist_s1 <= hist_mem[hist_raddr];
		end
	end

endmodule

// File: rtl/core/slcorr_mac.sv
// ----------------------------------------------------------------------------
// slcorr_mac
// Multiply-accumulate pipe: registered product, then a wrapping accumulator.
// ----------------------------------------------------------------------------
module slcorr_mac import slcorr_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mac_ctl_t                    mac_ctl,
	input  logic [SAMPLE_BITS-1:0]      coef_s1,
	input  logic [SAMPLE_BITS-1:0]      hist_s1,
	output logic signed [CORR_BITS-1:0] acc_q,
	output logic                        done_q
);

	logic                              v_s1, first_s1, last_s1;
	logic                              v_s2, first_s2, last_s2;
	logic signed [2*SAMPLE_BITS-1:0]   prod_s2;
	logic signed [CORR_BITS-1:0]       prod_ext;

	// Control travels alongside the memory read and the product.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= mac_ctl.issue;
			v_s2   <= v_s1;
			done_q <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= mac_ctl.first;
		last_s1  <= mac_ctl.last;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		if (v_s1) begin
			prod_s2 <= $signed(coef_s1) * $signed(hist_s1);
		end
	end

	// Sign-extend or wrap the product to the result width.
	assign prod_ext = CORR_BITS'(prod_s2);

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;
		end
	end

endmodule

// File: rtl/core/slcorr_ctrl.sv
// ----------------------------------------------------------------------------
// slcorr_ctrl
// Beat decode, history pointer, fill count and tap sequencer.
// ----------------------------------------------------------------------------
module slcorr_ctrl import slcorr_pkg::*; #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
	localparam int CW = $clog2(MAX_TAPS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic [TAP_INDEX_BITS-1:0] tap_index,
	input  logic [SAMPLE_BITS-1:0]    sample,
	input  logic [NUM_TAPS_BITS-1:0]  num_taps,
	input  logic                      res_done,
	input  logic                      out_free,
	output logic                      coef_we,
	output logic [AW-1:0]             coef_waddr,
	output logic                      hist_we,
	output logic [AW-1:0]             hist_waddr,
	output logic [SAMPLE_BITS-1:0]    wdata,
	output logic [AW-1:0]             coef_raddr,
	output logic [AW-1:0]             hist_raddr,
	output mac_ctl_t                  mac_ctl,
	output logic                      load,
	output state_t                    state
);

	localparam int NW = (CW > NUM_TAPS_BITS) ? CW : NUM_TAPS_BITS;
	localparam int SW = $clog2(2 * MAX_TAPS) + 1;
	localparam logic [AW-1:0] LAST_PTR = AW'(MAX_TAPS - 1);
	localparam logic [CW-1:0] FULL     = CW'(MAX_TAPS);
	localparam logic [NW-1:0] MAX_N    = NW'(MAX_TAPS);
	localparam logic [SW-1:0] DEPTH    = SW'(MAX_TAPS);

	state_t          state_q, state_d;
	logic [AW-1:0]   wptr_q, wptr_nxt;
	logic [CW-1:0]   fill_q, fill_nxt;
	logic [CW-1:0]   k_q, n_q, n_c;
	logic [AW-1:0]   rd_q, start_addr;
	logic [SW-1:0]   start_sum;
	logic [NW-1:0]   num_ext;
	logic            accept, is_write, is_push, is_restart, start_run, last_issue;

	assign accept     = in_valid && (state_q == ST_IDLE);
	assign is_write   = accept && (operation == OP_WRITE);
	assign is_push    = accept && (operation == OP_PUSH);
	assign is_restart = accept && (operation == OP_RESTART);

	// Zero taps acts as one, anything past the memory depth as the full depth.
	assign num_ext = NW'(num_taps);
	always_comb begin
		if (num_taps == '0) begin
			n_c = CW'(1);
		end else if (num_ext > MAX_N) begin
			n_c = FULL;
		end else begin
			n_c = CW'(num_ext);
		end
	end

	assign wptr_nxt = (wptr_q == LAST_PTR) ? '0 : wptr_q + AW'(1);
	assign fill_nxt = (fill_q == FULL) ? fill_q : fill_q + CW'(1);

	// Oldest sample of the window sits n-1 entries behind the newest.
	always_comb begin
		start_sum = SW'(wptr_nxt) + DEPTH - SW'(n_c) + SW'(1);
		if (start_sum >= DEPTH) begin
			start_sum = start_sum - DEPTH;
		end
		start_addr = AW'(start_sum);
	end

	assign start_run  = is_push && (fill_nxt >= n_c);
	assign last_issue = (k_q == n_q - CW'(1));

	// Write ports and read addresses.
	assign coef_we    = is_write && (32'(tap_index) < MAX_TAPS);
	assign coef_waddr = AW'(tap_index);
	assign hist_we    = is_push;
	assign hist_waddr = wptr_nxt;
	assign wdata      = sample;
	assign coef_raddr = AW'(k_q);
	assign hist_raddr = rd_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start_run)  state_d = ST_MAC;
			ST_MAC:   if (last_issue) state_d = ST_DRAIN;
			ST_DRAIN: if (res_done)   state_d = ST_HOLD;
			ST_HOLD:  if (out_free)   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != ST_IDLE);
		mac_ctl.issue = (state_q == ST_MAC);
		mac_ctl.first = (k_q == '0);
		mac_ctl.last  = last_issue;
		load          = (state_q == ST_HOLD) && out_free;
		state         = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wptr_q  <= '0;
			fill_q  <= '0;
			k_q     <= '0;
			n_q     <= CW'(1);
			rd_q    <= '0;
		end else begin
			state_q <= state_d;
			if (is_restart) begin
				fill_q <= '0;
			end
			if (is_push) begin
				wptr_q <= wptr_nxt;
				fill_q <= fill_nxt;
			end
			if (start_run) begin
				k_q  <= '0;
				n_q  <= n_c;
				rd_q <= start_addr;
			end else if (state_q == ST_MAC) begin
				k_q  <= k_q + CW'(1);
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + AW'(1);
			end
		end
	end

endmodule

// File: rtl/core/sliding_correlator.sv
// ----------------------------------------------------------------------------
// sliding_correlator
// Sliding cross-correlation of a sample stream against stored coefficients.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  input     in   in_valid / in_stall  operation, tap_index, value
//  result    out  out_valid/out_stall  correlation
//  config    in   cfg_we               cfg_wdata (num_taps)
//
//  Writes, restarts and pushes that leave the window short never stall the input.
//  A push that completes an N-tap window stalls the input while the N tap reads
//  issue, the read, multiply and accumulate registers drain, and the sum is handed off.
//  arst_n clears control state only; the memories start undefined.
//  While an untaken beat sits in the output register, the next sum waits
//  in the accumulator and the input stays stalled.
//
`include "sliding_correlator_macros.svh"

module sliding_correlator import slcorr_pkg::*; #(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [TAP_INDEX_BITS-1:0]   tap_index,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [CORR_BITS-1:0] correlation,
	input  logic                        cfg_we,
	input  logic [NUM_TAPS_BITS-1:0]    cfg_wdata
);

	localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

	logic [NUM_TAPS_BITS-1:0]    num_taps_q;
	logic [SAMPLE_BITS-1:0]      sample;
	logic                        coef_we, hist_we, load, res_done, out_free;
	logic [AW-1:0]               coef_waddr, hist_waddr, coef_raddr, hist_raddr;
	logic [SAMPLE_BITS-1:0]      wdata, coef_s1, hist_s1;
	logic signed [CORR_BITS-1:0] acc_q;
	logic                        out_valid_q;
	logic signed [CORR_BITS-1:0] corr_q;
	mac_ctl_t                    mac_ctl;
	state_t                      state;

	// Tap count register; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_taps_q <= NUM_TAPS_RESET;
		end else if (cfg_we) begin
			num_taps_q <= cfg_wdata;
		end
	end

	// Take the low SAMPLE_BITS of the raw beat; the sign sits at the top bit.
	assign sample = SAMPLE_BITS'($unsigned(value));

	slcorr_ctrl #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.tap_index (tap_index),
		.sample    (sample),
		.num_taps  (num_taps_q),
		.res_done  (res_done),
		.out_free  (out_free),
		.coef_we   (coef_we),
		.coef_waddr(coef_waddr),
		.hist_we   (hist_we),
		.hist_waddr(hist_waddr),
		.wdata     (wdata),
		.coef_raddr(coef_raddr),
		.hist_raddr(hist_raddr),
		.mac_ctl   (mac_ctl),
		.load      (load),
		.state     (state)
	);

	slcorr_store #(
		.MAX_TAPS   (MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_store (
		.clk       (clk),
		.coef_we   (coef_we),
		.coef_waddr(coef_waddr),
		.hist_we   (hist_we),
		.hist_waddr(hist_waddr),
		.wdata     (wdata),
		.mac_ctl   (mac_ctl),
		.coef_raddr(coef_raddr),
		.hist_raddr(hist_raddr),
		.coef_s1   (coef_s1),
		.hist_s1   (hist_s1)
	);

	slcorr_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.mac_ctl(mac_ctl),
		.coef_s1(coef_s1),
		.hist_s1(hist_s1),
		.acc_q  (acc_q),
		.done_q (res_done)
	);

	// Output register: free when empty or when its beat leaves this cycle.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Hold the sum until it is taken; load only into a free slot.
	always_ff @(posedge clk) begin
		if (load) begin
			corr_q <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign correlation = corr_q;

	// Never overwrite a result that is still waiting.
	`SLC_ASSERT_SAME(a_load_free, load, !out_valid_q || !out_stall, "load into busy output")
	// The final accumulation lands only while the sequencer drains.
	`SLC_ASSERT_SAME(a_done_drain, res_done, state == ST_DRAIN, "sum done outside drain")
	// No tap step is issued while input beats are taken.
	`SLC_ASSERT_SAME(a_issue_stall, mac_ctl.issue, in_stall, "tap issued while accepting")
	// A loaded result shows up as valid in the next cycle.
	`SLC_ASSERT_NEXT(a_load_valid, load, out_valid, "loaded result not valid")

endmodule
